// ===== hw/rtl/two_vector_orthonormalize_unit_macros.svh =====
// Assertion helpers for the orthonormalize unit checkers.
`ifndef TWO_VECTOR_ORTHONORMALIZE_UNIT_MACROS_SVH
`define TWO_VECTOR_ORTHONORMALIZE_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define TVO_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("orthonormalize unit: assertion failed");

// Check that an antecedent is followed by a consequent in the next cycle.
`define TVO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("orthonormalize unit: assertion failed");

`endif

// ===== hw/rtl/tvo_pkg.sv =====
package tvo_pkg;

    localparam int VECTOR_LANES    = 4;
    localparam int RSQRT_SEED_BITS = 8;
    localparam int NEWTON_STEPS    = 3;
    localparam int COMP_W          = 16;
    localparam int ONE_Q14         = 16384;
    localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

    // Seed for the reciprocal square root table, evaluated at elaboration.
    function automatic logic [30:0] seed_value(input int idx, input int sb);
        logic [63:0] mid;
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        mid  = (((64'(idx)) << 1) | 64'd1) << (31 - sb);
        num  = 64'd1 << 62;
        quo  = '0;
        rem  = '0;
        // long division of 2^62 by the bucket midpoint
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= mid) begin
                rem    = rem - mid;
                quo[i] = 1'b1;
            end
        end
        // integer square root, two bits a step
        x    = quo;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return 31'(res << 14);
    endfunction

endpackage

// ===== hw/rtl/tvo_lane_mul.sv =====
module tvo_lane_mul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [B_W-1:0]      i_b,
    output logic signed [A_W+B_W-1:0]  o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    // Register one lane product when the stage loads
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/tvo_merge.sv =====
module tvo_merge #(
    parameter int N     = 4,
    parameter int IN_W  = 32,
    parameter int OUT_W = 34
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [N-1:0][IN_W-1:0]      i_term,
    output logic signed [OUT_W-1:0]     o_sum
);

    logic signed [OUT_W-1:0] n_sum;
    logic signed [OUT_W-1:0] r_sum;

    // Add the lane terms, sign extended
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < N; i++) begin
            n_sum = n_sum + OUT_W'($signed(i_term[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== hw/rtl/tvo_norm.sv =====
module tvo_norm #(
    parameter int VW        = 16,
    parameter int SIDE_W    = 1,
    parameter int SEED_BITS = tvo_pkg::RSQRT_SEED_BITS
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_valid,
    output logic                                                o_ready,
    input  logic [tvo_pkg::VECTOR_LANES-1:0][VW-1:0]            i_vec,
    input  logic [SIDE_W-1:0]                                   i_side,
    output logic                                                o_valid,
    input  logic                                                i_ready,
    output logic [tvo_pkg::VECTOR_LANES-1:0][tvo_pkg::COMP_W-1:0] o_vec,
    output logic                                                o_zero,
    output logic [SIDE_W-1:0]                                   o_side
);

    localparam int L      = tvo_pkg::VECTOR_LANES;
    localparam int SW     = 2 * VW + $clog2(L);
    localparam int MSB_W  = $clog2(SW);
    localparam int PW     = VW + 32;
    localparam int CW     = tvo_pkg::COMP_W;
    localparam int ST_SQ    = 0;
    localparam int ST_SUM   = 1;
    localparam int ST_MSB   = 2;
    localparam int ST_NORM  = 3;
    localparam int ST_SEED  = 4;
    localparam int ST_NEWT  = 5;
    localparam int ST_SCALE = ST_NEWT + 3 * tvo_pkg::NEWTON_STEPS;
    localparam int ST_OUT   = ST_SCALE + 1;
    localparam int NST      = ST_OUT + 1;

    typedef struct packed {
        logic [L-1:0][VW-1:0] v;
        logic [SIDE_W-1:0]    side;
        logic [SW-1:0]        s;
        logic                 zero;
        logic [MSB_W-1:0]     msb;
        logic [31:0]          m;
        logic signed [6:0]    half;
        logic [30:0]          y;
        logic [30:0]          t;
        logic [32:0]          h;
        logic [L-1:0][CW-1:0] u;
    } t_ctx;

    t_ctx                      r_ctx [NST];
    t_ctx                      n_ctx [NST];
    logic [NST-1:0]            r_vld;
    logic [NST-1:0]            w_rdy;
    logic [L-1:0][2*VW-1:0]    w_sq;
    logic [L-1:0][PW-1:0]      w_prod;
    logic signed [SW:0]        w_sum;
    logic [30:0]               w_rom [2**SEED_BITS];

    // Seed table
    genvar g;
    for (g = 0; g < 2**SEED_BITS; g++) begin : g_rom
        assign w_rom[g] = tvo_pkg::seed_value(g, SEED_BITS);
    end

    // Lane squares and lane scaling
    for (g = 0; g < L; g++) begin : g_lane
        tvo_lane_mul #(.A_W(VW), .B_W(VW)) u_sq (
            .i_clk (i_clk),
            .i_en  (w_rdy[ST_SQ]),
            .i_a   ($signed(i_vec[g])),
            .i_b   ($signed(i_vec[g])),
            .o_p   (w_sq[g])
        );
        tvo_lane_mul #(.A_W(VW), .B_W(32)) u_scale (
            .i_clk (i_clk),
            .i_en  (w_rdy[ST_SCALE]),
            .i_a   ($signed(r_ctx[ST_SCALE-1].v[g])),
            .i_b   ($signed({1'b0, r_ctx[ST_SCALE-1].y})),
            .o_p   (w_prod[g])
        );
    end

    // Merge the squared lanes
    tvo_merge #(.N(L), .IN_W(2 * VW), .OUT_W(SW + 1)) u_sum (
        .i_clk  (i_clk),
        .i_en   (w_rdy[ST_SUM]),
        .i_term (w_sq),
        .o_sum  (w_sum)
    );

    // Stall chain: a stage loads when empty or when its successor loads
    always_comb begin
        w_rdy[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Stage datapath
    always_comb begin
        logic [MSB_W-1:0] r_sh;
        logic [MSB_W-1:0] l_sh;
        logic [61:0]      p_yy;
        logic [62:0]      p_mt;
        logic [31:0]      d;
        logic [62:0]      p_yd;
        logic [6:0]       sh;
        logic [PW-1:0]    mag;
        logic [PW-1:0]    q;
        logic [PW-1:0]    rnd;
        logic [CW-1:0]    mag_u;
        int               ph;
        for (int k = 0; k < NST; k++) begin
            r_sh  = '0;
            l_sh  = '0;
            p_yy  = '0;
            p_mt  = '0;
            d     = '0;
            p_yd  = '0;
            sh    = '0;
            mag   = '0;
            q     = '0;
            rnd   = '0;
            mag_u = '0;
            ph    = 0;
            if (k == 0) begin
                n_ctx[k]      = r_ctx[k];
                n_ctx[k].v    = i_vec;
                n_ctx[k].side = i_side;
            end else begin
                n_ctx[k] = r_ctx[k-1];
            end
            if (k == ST_MSB) begin
                n_ctx[k].s    = w_sum[SW-1:0];
                n_ctx[k].zero = (w_sum[SW-1:0] == '0);
                n_ctx[k].msb  = '0;
                for (int b = 0; b < SW; b++) begin
                    if (w_sum[b]) begin
                        n_ctx[k].msb = MSB_W'(b);
                    end
                end
            end
            if (k == ST_NORM) begin
                if (r_ctx[k-1].msb >= MSB_W'(30)) begin
                    r_sh = (r_ctx[k-1].msb - MSB_W'(30)) & ~MSB_W'(1);
                    n_ctx[k].m    = 32'(r_ctx[k-1].s >> r_sh);
                    n_ctx[k].half = 7'(r_sh >> 1);
                end else begin
                    l_sh = (MSB_W'(31) - r_ctx[k-1].msb) & ~MSB_W'(1);
                    n_ctx[k].m    = 32'(r_ctx[k-1].s << l_sh);
                    n_ctx[k].half = -7'(l_sh >> 1);
                end
            end
            if (k == ST_SEED) begin
                n_ctx[k].y = w_rom[r_ctx[k-1].m[31 -: SEED_BITS]];
            end
            if (k >= ST_NEWT && k < ST_SCALE) begin
                ph = (k - ST_NEWT) % 3;
                if (ph == 0) begin
                    p_yy       = r_ctx[k-1].y * r_ctx[k-1].y;
                    n_ctx[k].t = p_yy[60:30];
                end else if (ph == 1) begin
                    p_mt       = r_ctx[k-1].m * r_ctx[k-1].t;
                    n_ctx[k].h = p_mt[62:30];
                end else begin
                    d          = (r_ctx[k-1].h >= {1'b0, tvo_pkg::THREE_Q30}) ? '0 :
                                 32'({1'b0, tvo_pkg::THREE_Q30} - r_ctx[k-1].h);
                    p_yd       = r_ctx[k-1].y * d;
                    n_ctx[k].y = p_yd[61:31];
                end
            end
            if (k == ST_OUT) begin
                sh = 7'(7'sd31 + r_ctx[k-1].half);
                for (int i = 0; i < L; i++) begin
                    mag   = w_prod[i][PW-1] ? -w_prod[i] : w_prod[i];
                    q     = mag >> (sh - 7'd1);
                    rnd   = (q + PW'(1)) >> 1;
                    mag_u = (rnd > PW'(tvo_pkg::ONE_Q14)) ? CW'(tvo_pkg::ONE_Q14) : rnd[CW-1:0];
                    if (r_ctx[k-1].zero) begin
                        n_ctx[k].u[i] = '0;
                    end else begin
                        n_ctx[k].u[i] = w_prod[i][PW-1] ? -mag_u : mag_u;
                    end
                end
            end
        end
    end

    // Hold stage data
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (w_rdy[k]) begin
                r_ctx[k] <= n_ctx[k];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NST-1];
    assign o_vec   = r_ctx[NST-1].u;
    assign o_zero  = r_ctx[NST-1].zero;
    assign o_side  = r_ctx[NST-1].side;

endmodule

// ===== hw/rtl/two_vector_orthonormalize_unit.sv =====
// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_src_x..w, i_tgt_x..w (signed Q8.8)
// output    o_valid   i_stall   o_unit_src_x..w, o_ortho_tgt_x..w (Q1.14),
//                               o_src_zero, o_tgt_zero
//
// One beat enters per clock while o_stall is low; each beat passes 36 register
// stages before it is offered on the output, set by two normalizer pipelines of
// 16 stages (three Newton steps of three multiplier stages each) and four
// projection stages in between.
// Every stage holds its own valid bit; a stall on the output fills empty
// stages first, so the input keeps taking beats until the pipe is full.
// Reset clears the valid bits only.
module two_vector_orthonormalize_unit #(
    parameter int RSQRT_SEED_BITS = tvo_pkg::RSQRT_SEED_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_src_x,
    input  logic signed [15:0] i_src_y,
    input  logic signed [15:0] i_src_z,
    input  logic signed [15:0] i_src_w,
    input  logic signed [15:0] i_tgt_x,
    input  logic signed [15:0] i_tgt_y,
    input  logic signed [15:0] i_tgt_z,
    input  logic signed [15:0] i_tgt_w,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_unit_src_x,
    output logic signed [15:0] o_unit_src_y,
    output logic signed [15:0] o_unit_src_z,
    output logic signed [15:0] o_unit_src_w,
    output logic signed [15:0] o_ortho_tgt_x,
    output logic signed [15:0] o_ortho_tgt_y,
    output logic signed [15:0] o_ortho_tgt_z,
    output logic signed [15:0] o_ortho_tgt_w,
    output logic               o_src_zero,
    output logic               o_tgt_zero
);

    localparam int L   = tvo_pkg::VECTOR_LANES;
    localparam int CW  = tvo_pkg::COMP_W;
    localparam int DW  = 2 * CW + $clog2(L);
    localparam int QW  = CW + DW;
    localparam int BW  = CW + 1 + $clog2(L + 1);
    localparam int OST = 4;

    typedef struct packed {
        logic [L-1:0][CW-1:0] t;
        logic [L-1:0][CW-1:0] u;
        logic                 za;
        logic [L-1:0][BW-1:0] b;
    } t_octx;

    logic [L-1:0][CW-1:0]   w_src;
    logic [L-1:0][CW-1:0]   w_tgt;
    logic                   w_n1_ready;
    logic                   w_n1_valid;
    logic [L-1:0][CW-1:0]   w_n1_u;
    logic                   w_n1_zero;
    logic [L-1:0][CW-1:0]   w_n1_t;
    logic                   w_n2_ready;
    logic [L-1:0][CW-1:0]   w_n2_u;
    logic [L*CW:0]          w_n2_side;
    logic [L-1:0][2*CW-1:0] w_dot;
    logic signed [DW-1:0]   w_d;
    logic [L-1:0][QW-1:0]   w_q;
    t_octx                  r_oc [OST];
    t_octx                  n_oc [OST];
    logic [OST-1:0]         r_ov;
    logic [OST-1:0]         w_ordy;

    assign w_src = {i_src_w, i_src_z, i_src_y, i_src_x};
    assign w_tgt = {i_tgt_w, i_tgt_z, i_tgt_y, i_tgt_x};

    // Normalize the first vector, carrying the second alongside
    tvo_norm #(.VW(CW), .SIDE_W(L * CW), .SEED_BITS(RSQRT_SEED_BITS)) u_norm_src (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_n1_ready),
        .i_vec   (w_src),
        .i_side  (w_tgt),
        .o_valid (w_n1_valid),
        .i_ready (w_ordy[0]),
        .o_vec   (w_n1_u),
        .o_zero  (w_n1_zero),
        .o_side  (w_n1_t)
    );

    assign o_stall = !w_n1_ready;

    // Lane products for the dot product and the projection
    genvar g;
    for (g = 0; g < L; g++) begin : g_lane
        tvo_lane_mul #(.A_W(CW), .B_W(CW)) u_dot (
            .i_clk (i_clk),
            .i_en  (w_ordy[0]),
            .i_a   ($signed(w_n1_t[g])),
            .i_b   ($signed(w_n1_u[g])),
            .o_p   (w_dot[g])
        );
        tvo_lane_mul #(.A_W(CW), .B_W(DW)) u_proj (
            .i_clk (i_clk),
            .i_en  (w_ordy[2]),
            .i_a   ($signed(r_oc[1].u[g])),
            .i_b   (w_d),
            .o_p   (w_q[g])
        );
    end

    tvo_merge #(.N(L), .IN_W(2 * CW), .OUT_W(DW)) u_dot_sum (
        .i_clk  (i_clk),
        .i_en   (w_ordy[1]),
        .i_term (w_dot),
        .o_sum  (w_d)
    );

    // Stall chain of the projection stages
    always_comb begin
        w_ordy[OST-1] = !r_ov[OST-1] || w_n2_ready;
        for (int k = OST - 2; k >= 0; k--) begin
            w_ordy[k] = !r_ov[k] || w_ordy[k+1];
        end
    end

    // Projection stages: carry vectors, then subtract the rounded projection
    always_comb begin
        logic [QW-1:0] mag;
        logic [QW:0]   rnd;
        logic [BW-1:0] p;
        for (int k = 0; k < OST; k++) begin
            mag = '0;
            rnd = '0;
            p   = '0;
            if (k == 0) begin
                n_oc[k]    = r_oc[k];
                n_oc[k].t  = w_n1_t;
                n_oc[k].u  = w_n1_u;
                n_oc[k].za = w_n1_zero;
            end else begin
                n_oc[k] = r_oc[k-1];
            end
            if (k == OST - 1) begin
                for (int i = 0; i < L; i++) begin
                    mag = w_q[i][QW-1] ? -w_q[i] : w_q[i];
                    rnd = ({1'b0, mag} + (QW+1)'(1 << 27)) >> 28;
                    p   = w_q[i][QW-1] ? -rnd[BW-1:0] : rnd[BW-1:0];
                    n_oc[k].b[i] = BW'($signed(r_oc[k-1].t[i])) - p;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < OST; k++) begin
            if (w_ordy[k]) begin
                r_oc[k] <= n_oc[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= '0;
        end else begin
            for (int k = 0; k < OST; k++) begin
                if (w_ordy[k]) begin
                    r_ov[k] <= (k == 0) ? w_n1_valid : r_ov[k-1];
                end
            end
        end
    end

    // Normalize the remainder, carrying the unit vector and its flag
    tvo_norm #(.VW(BW), .SIDE_W(L * CW + 1), .SEED_BITS(RSQRT_SEED_BITS)) u_norm_tgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_ov[OST-1]),
        .o_ready (w_n2_ready),
        .i_vec   (r_oc[OST-1].b),
        .i_side  ({r_oc[OST-1].u, r_oc[OST-1].za}),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_vec   (w_n2_u),
        .o_zero  (o_tgt_zero),
        .o_side  (w_n2_side)
    );

    assign o_src_zero    = w_n2_side[0];
    assign o_unit_src_x  = w_n2_side[1 +: CW];
    assign o_unit_src_y  = w_n2_side[1 + CW +: CW];
    assign o_unit_src_z  = w_n2_side[1 + 2 * CW +: CW];
    assign o_unit_src_w  = w_n2_side[1 + 3 * CW +: CW];
    assign o_ortho_tgt_x = w_n2_u[0];
    assign o_ortho_tgt_y = w_n2_u[1];
    assign o_ortho_tgt_z = w_n2_u[2];
    assign o_ortho_tgt_w = w_n2_u[3];

endmodule

// ===== hw/rtl/tvo_checker.sv =====
`include "two_vector_orthonormalize_unit_macros.svh"

module tvo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_unit_src_x,
    input logic signed [15:0] o_unit_src_y,
    input logic signed [15:0] o_unit_src_z,
    input logic signed [15:0] o_unit_src_w,
    input logic signed [15:0] o_ortho_tgt_x,
    input logic signed [15:0] o_ortho_tgt_y,
    input logic signed [15:0] o_ortho_tgt_z,
    input logic signed [15:0] o_ortho_tgt_w,
    input logic               o_src_zero,
    input logic               o_tgt_zero
);

    // A zero first vector yields an all-zero unit vector
    `TVO_ASSERT(a_src_zero_clears, !(o_valid && o_src_zero) || (o_unit_src_x == 0 && o_unit_src_y == 0 && o_unit_src_z == 0 && o_unit_src_w == 0))

    // A zero remainder yields an all-zero second vector
    `TVO_ASSERT(a_tgt_zero_clears, !(o_valid && o_tgt_zero) || (o_ortho_tgt_x == 0 && o_ortho_tgt_y == 0 && o_ortho_tgt_z == 0 && o_ortho_tgt_w == 0))

    // The x components of both output vectors stay within plus or minus one
    `TVO_ASSERT(a_unit_range, !o_valid || (o_unit_src_x <= 16384 && o_unit_src_x >= -16384 && o_ortho_tgt_x <= 16384 && o_ortho_tgt_x >= -16384))

    // A stalled result beat stays offered
    `TVO_ASSERT_NEXT(a_valid_holds, o_valid && i_stall, o_valid)

endmodule

bind two_vector_orthonormalize_unit tvo_checker u_tvo_checker (.*);
